>>> hw/rtl/tmsc_pkg.sv
// Shared types and constants for the tile map slide collision block.
// Used by every module under hw/rtl; depends on nothing.
package tmsc_pkg;

   localparam int POS_W        = 24;              // Q16.8 position
   localparam int CW           = POS_W + 1;       // corner coordinate, signed
   localparam int NCORNER      = 8;               // divider lanes
   localparam int NUM_LOAD_OPS = 5;
   localparam int QDEPTH       = 2;
   localparam int QPTR_W       = $clog2(QDEPTH);
   localparam int QCNT_W       = $clog2(QDEPTH + 1);
   localparam int REQ_TDATA_W  = 136;
   localparam int RSP_TDATA_W  = 80;
   localparam int CSR_DATA_W   = 16;
   localparam int CSR_INDEX_W  = 2;
   localparam int DEF_MAX_CELLS_WIDE = 32;
   localparam int DEF_MAX_CELLS_HIGH = 32;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_MOVE = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] CSR_CELLS_WIDE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CELLS_HIGH = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TILE_EDGE  = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_RADIUS     = 2'd3;

   // open bits of a load, index = load step
   localparam int OP_CENTER = 0;
   localparam int OP_NORTH  = 1;
   localparam int OP_WEST   = 2;
   localparam int OP_SOUTH  = 3;
   localparam int OP_EAST   = 4;

   // corner lanes: x lanes 0..3, z lanes 4..7
   typedef struct packed {
      logic                            is_move;
      logic [4:0]                      col;
      logic [4:0]                      row;
      logic [NUM_LOAD_OPS-1:0]         open;
      logic [NCORNER-1:0][CW-1:0]      corner;
      logic [POS_W-1:0]                now_x;
      logic [POS_W-1:0]                now_y;
      logic [POS_W-1:0]                now_z;
      logic [POS_W-1:0]                goal_x;
      logic [POS_W-1:0]                goal_z;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_stat_type;

   typedef enum logic [5:0] {
      ST_CLEAR = 6'b000001,
      ST_IDLE  = 6'b000010,
      ST_LOAD  = 6'b000100,
      ST_DIV   = 6'b001000,
      ST_READ  = 6'b010000,
      ST_DONE  = 6'b100000
   } back_state_type;

endpackage

>>> hw/rtl/tmsc_div.sv
// One restoring divider lane: floor tile index of a corner coordinate.
// Uses tmsc_pkg; instantiated by tmsc_back.
module tmsc_div #(
   parameter int QW = 7
) (
   input  logic                   clock,
   input  logic                   start,
   input  logic                   step,
   input  logic [tmsc_pkg::CW-1:0] coord,
   input  logic [15:0]            divisor,
   input  logic [QW:0]            limit,
   output logic [QW-1:0]          quot,
   output logic                   oob
);
   import tmsc_pkg::*;

   localparam int WW = 26 + QW;

   logic [WW-1:0] rem_ff, rem_in;
   logic [WW-1:0] dsh_ff, dsh_in;
   logic [QW-1:0] q_ff, q_in;
   logic          oob_ff, oob_in;
   logic [WW-1:0] mag;
   logic [WW-1:0] dfull;

   assign mag   = WW'(coord[CW-2:0]);
   assign dfull = WW'(divisor) << QW;

   always_comb begin
      rem_in = rem_ff;
      dsh_in = dsh_ff;
      q_in   = q_ff;
      oob_in = oob_ff;
      if (start) begin
         rem_in = mag;
         dsh_in = WW'(divisor) << (QW - 1);
         q_in   = '0;
         // negative coordinate or quotient beyond any map: solid
         oob_in = coord[CW-1] | (mag >= dfull);
      end else if (step) begin
         dsh_in = dsh_ff >> 1;
         if (rem_ff >= dsh_ff) begin
            rem_in = rem_ff - dsh_ff;
            q_in   = {q_ff[QW-2:0], 1'b1};
         end else begin
            q_in   = {q_ff[QW-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      q_ff   <= q_in;
      oob_ff <= oob_in;
   end

   assign quot = q_ff;
   assign oob  = oob_ff | ({1'b0, q_ff} >= limit);

endmodule

>>> hw/rtl/tmsc_fifo.sv
// Short job queue between the front and back parts.
// Uses tmsc_pkg job_type and queue_stat_type.
module tmsc_fifo (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  tmsc_pkg::job_type          din,
   input  logic                       pop,
   output tmsc_pkg::job_type          dout,
   output tmsc_pkg::queue_stat_type   stat
);
   import tmsc_pkg::*;

   job_type            slot_ff [QDEPTH];
   logic [QPTR_W-1:0]  wr_ff, wr_in;
   logic [QPTR_W-1:0]  rd_ff, rd_in;
   logic [QCNT_W-1:0]  cnt_ff, cnt_in;

   always_comb begin
      wr_in  = push ? QPTR_W'(wr_ff + 1'b1) : wr_ff;
      rd_in  = pop  ? QPTR_W'(rd_ff + 1'b1) : rd_ff;
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = QCNT_W'(cnt_ff + 1'b1);
      end else if (pop && !push) begin
         cnt_in = QCNT_W'(cnt_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= din;
      end
   end

   assign dout       = slot_ff[rd_ff];
   assign stat.full  = (cnt_ff == QCNT_W'(QDEPTH));
   assign stat.empty = (cnt_ff == '0);

endmodule

>>> hw/rtl/tmsc_front.sv
// Front part: accepts request items, drops loads outside the maze, builds jobs.
// Uses tmsc_pkg; feeds tmsc_fifo.
module tmsc_front (
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic                             req_tuser,
   input  logic [tmsc_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  logic [15:0]                      body_radius,
   input  logic [5:0]                       eff_w,
   input  logic [5:0]                       eff_h,
   input  logic                             clearing,
   input  tmsc_pkg::queue_stat_type         qstat,
   output logic                             push,
   output tmsc_pkg::job_type                job
);
   import tmsc_pkg::*;

   logic [4:0]       col, row;
   logic             wn, ws, we, ww;
   logic             load_ok;
   logic [CW-1:0]    rad, nx, nz, gx, gz;

   assign col = req_tdata[4:0];
   assign row = req_tdata[9:5];
   assign wn  = req_tdata[10];
   assign ws  = req_tdata[11];
   assign we  = req_tdata[12];
   assign ww  = req_tdata[13];

   assign rad = CW'(body_radius);
   assign nx  = {req_tdata[37],  req_tdata[37:14]};
   assign nz  = {req_tdata[85],  req_tdata[85:62]};
   assign gx  = {req_tdata[109], req_tdata[109:86]};
   assign gz  = {req_tdata[133], req_tdata[133:110]};

   assign load_ok    = ({1'b0, col} < eff_w) && ({1'b0, row} < eff_h);
   assign req_tready = !clearing && !qstat.full;
   assign push       = req_tvalid && req_tready && ((req_tuser == CMD_MOVE) || load_ok);

   always_comb begin
      job.is_move         = (req_tuser == CMD_MOVE);
      job.col             = col;
      job.row             = row;
      job.open[OP_CENTER] = 1'b1;
      job.open[OP_NORTH]  = !wn;
      job.open[OP_WEST]   = !ww;
      job.open[OP_SOUTH]  = ({1'b0, row} == 6'(eff_h - 6'd1)) && !ws;
      job.open[OP_EAST]   = ({1'b0, col} == 6'(eff_w - 6'd1)) && !we;
      job.corner[0]       = gx - rad;
      job.corner[1]       = gx + rad;
      job.corner[2]       = nx - rad;
      job.corner[3]       = nx + rad;
      job.corner[4]       = nz - rad;
      job.corner[5]       = nz + rad;
      job.corner[6]       = gz - rad;
      job.corner[7]       = gz + rad;
      job.now_x           = req_tdata[37:14];
      job.now_y           = req_tdata[61:38];
      job.now_z           = req_tdata[85:62];
      job.goal_x          = req_tdata[109:86];
      job.goal_z          = req_tdata[133:110];
   end

endmodule

>>> hw/rtl/tmsc_back.sv
// Back part: tile map memory, clear sweep, load writes, corner division and
// tile tests, result register. Uses tmsc_pkg and tmsc_div.
module tmsc_back #(
   parameter int MAX_CELLS_WIDE = tmsc_pkg::DEF_MAX_CELLS_WIDE,
   parameter int MAX_CELLS_HIGH = tmsc_pkg::DEF_MAX_CELLS_HIGH
) (
   input  logic                             clock,
   input  logic                             reset,
   input  tmsc_pkg::job_type                job,
   input  tmsc_pkg::queue_stat_type         qstat,
   output logic                             job_pop,
   input  logic [5:0]                       eff_w,
   input  logic [5:0]                       eff_h,
   input  logic [15:0]                      tile_edge_eff,
   output logic                             clearing,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [tmsc_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import tmsc_pkg::*;

   localparam int TW    = 2 * MAX_CELLS_WIDE + 1;
   localparam int TH    = 2 * MAX_CELLS_HIGH + 1;
   localparam int TILES = TW * TH;
   localparam int AW    = $clog2(TILES);
   localparam int QW    = $clog2((TW > TH) ? TW : TH);

   back_state_type state_ff, state_in;
   logic [3:0]     step_ff, step_in;
   logic [AW-1:0]  clr_ff, clr_in;
   logic           xblk_ff, xblk_in;
   logic           zblk_ff, zblk_in;
   logic           pend_ff, pend_in;
   logic           pend_oob_ff, pend_oob_in;
   logic           pend_z_ff, pend_z_in;
   logic           rsp_valid_ff, rsp_valid_in;
   job_type        job_ff, job_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic           tile_mem [TILES];
   logic           rdata_ff;
   logic           mem_we, mem_wd;
   logic [AW-1:0]  waddr, raddr;

   logic [QW:0]    w_lim, h_lim;
   logic [QW-1:0]  lane_q   [NCORNER];
   logic           lane_oob [NCORNER];
   logic           lane_start, lane_step;

   logic           zphase, issue, hit, load_rsp;
   logic [1:0]     cj;
   logic [2:0]     xl, zl;
   logic [QW-1:0]  tx, tz;
   logic           rd_oob;
   logic [6:0]     ltx, ltz, c2, r2;
   logic [POS_W-1:0] res_x, res_z;

   assign w_lim = (QW + 1)'({2'b0, eff_w, 1'b1});
   assign h_lim = (QW + 1)'({2'b0, eff_h, 1'b1});

   assign lane_start = job_pop && job.is_move;
   assign lane_step  = (state_ff == ST_DIV);

   for (genvar i = 0; i < NCORNER; i++) begin : g_lane
      tmsc_div #(.QW(QW)) u_div (
         .clock   (clock),
         .start   (lane_start),
         .step    (lane_step),
         .coord   (job.corner[i]),
         .divisor (tile_edge_eff),
         .limit   ((i < NCORNER / 2) ? w_lim : h_lim),
         .quot    (lane_q[i]),
         .oob     (lane_oob[i])
      );
   end

   // corner reads: steps 0..3 test X, step 4 drains, steps 5..8 test Z
   // at goal X (lanes 0,1) or, when X was blocked, at current X (lanes 2,3)
   always_comb begin
      zphase = (step_ff >= 4'd5);
      cj     = zphase ? 2'(step_ff - 4'd5) : step_ff[1:0];
      issue  = (state_ff == ST_READ) && (step_ff != 4'd4) && (step_ff <= 4'd8);
      if (zphase) begin
         xl = {1'b0, xblk_ff, cj[1]};
         zl = {2'b11, cj[0]};
      end else begin
         xl = {2'b00, cj[1]};
         zl = {2'b10, cj[0]};
      end
      tx     = lane_q[xl];
      tz     = lane_q[zl];
      rd_oob = lane_oob[xl] | lane_oob[zl];
      raddr  = rd_oob ? '0 : AW'(AW'(tx) * AW'(TH) + AW'(tz));
   end

   // load tile coordinates
   always_comb begin
      c2 = {1'b0, job_ff.col, 1'b0};
      r2 = {1'b0, job_ff.row, 1'b0};
      unique case (step_ff[2:0])
         3'd1: begin
            ltx = c2 + 7'd1;
            ltz = r2;
         end
         3'd2: begin
            ltx = c2;
            ltz = r2 + 7'd1;
         end
         3'd3: begin
            ltx = c2 + 7'd1;
            ltz = r2 + 7'd2;
         end
         3'd4: begin
            ltx = c2 + 7'd2;
            ltz = r2 + 7'd1;
         end
         default: begin
            ltx = c2 + 7'd1;
            ltz = r2 + 7'd1;
         end
      endcase
   end

   always_comb begin
      mem_we = 1'b0;
      mem_wd = 1'b0;
      waddr  = AW'(AW'(ltx) * AW'(TH) + AW'(ltz));
      if (state_ff == ST_CLEAR) begin
         mem_we = 1'b1;
         mem_wd = 1'b1;
         waddr  = clr_ff;
      end else if (state_ff == ST_LOAD) begin
         mem_we = job_ff.open[step_ff[2:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         tile_mem[waddr] <= mem_wd;
      end
      rdata_ff <= tile_mem[raddr];
   end

   assign hit      = pend_oob_ff | rdata_ff;
   assign res_x    = xblk_ff ? job_ff.now_x : job_ff.goal_x;
   assign res_z    = zblk_ff ? job_ff.now_z : job_ff.goal_z;
   assign load_rsp = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      clr_in       = clr_ff;
      xblk_in      = xblk_ff;
      zblk_in      = zblk_ff;
      job_in       = job_ff;
      job_pop      = 1'b0;
      pend_in      = issue;
      pend_oob_in  = rd_oob;
      pend_z_in    = zphase;
      rsp_valid_in = (rsp_valid_ff && !rsp_tready) || load_rsp;
      rsp_data_in  = rsp_data_ff;
      if (pend_ff && hit) begin
         if (pend_z_ff) begin
            zblk_in = 1'b1;
         end else begin
            xblk_in = 1'b1;
         end
      end
      unique case (state_ff)
         ST_CLEAR: begin
            clr_in = AW'(clr_ff + 1'b1);
            if (clr_ff == AW'(TILES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (!qstat.empty) begin
               job_pop  = 1'b1;
               job_in   = job;
               step_in  = '0;
               xblk_in  = 1'b0;
               zblk_in  = 1'b0;
               state_in = job.is_move ? ST_DIV : ST_LOAD;
            end
         end
         ST_LOAD: begin
            step_in = step_ff + 4'd1;
            if (step_ff == 4'(NUM_LOAD_OPS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_DIV: begin
            step_in = step_ff + 4'd1;
            if (step_ff == 4'(QW - 1)) begin
               step_in  = '0;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            step_in = step_ff + 4'd1;
            if (step_ff == 4'd9) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (load_rsp) begin
               rsp_data_in = RSP_TDATA_W'({!zblk_ff, !xblk_ff, res_z, job_ff.now_y, res_x});
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         step_ff      <= '0;
         clr_ff       <= '0;
         xblk_ff      <= 1'b0;
         zblk_ff      <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         clr_ff       <= clr_in;
         xblk_ff      <= xblk_in;
         zblk_ff      <= zblk_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff      <= job_in;
      pend_oob_ff <= pend_oob_in;
      pend_z_ff   <= pend_z_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign clearing   = (state_ff == ST_CLEAR);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

>>> hw/rtl/tile_map_slide_collision.sv
// Tile map slide collision top level. A move passes eight divider lanes of QW
// steps (QW = quotient bits, 7 at default size), then eight tile reads through
// one read port; a load makes up to five tile writes. The back end finishes each
// item before it takes the next; the queue takes an item per cycle while not full or clearing.
// Reset is synchronous; afterwards a sweep over all (2*MAX_CELLS_WIDE+1)*(2*MAX_CELLS_HIGH+1)
// tiles marks every tile solid while req_tready stays low.
module tile_map_slide_collision #(
   parameter int MAX_CELLS_WIDE = tmsc_pkg::DEF_MAX_CELLS_WIDE,
   parameter int MAX_CELLS_HIGH = tmsc_pkg::DEF_MAX_CELLS_HIGH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [tmsc_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [tmsc_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // command
   input  logic                              req_tuser,
   // cell_col, cell_row, wall_n, wall_s, wall_e, wall_w, now_x, now_y, now_z,
   // goal_x, goal_z, zero pad
   input  logic [tmsc_pkg::REQ_TDATA_W-1:0]  req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // next_x, next_y, next_z, x_taken, z_taken, zero pad
   output logic [tmsc_pkg::RSP_TDATA_W-1:0]  rsp_tdata
);
   import tmsc_pkg::*;

   logic [5:0]     cells_wide_ff, cells_wide_in;
   logic [5:0]     cells_high_ff, cells_high_in;
   logic [15:0]    tile_edge_ff, tile_edge_in;
   logic [15:0]    radius_ff, radius_in;
   logic [5:0]     eff_w, eff_h;
   logic [15:0]    tile_edge_eff;
   logic           clearing, push, pop;
   job_type        fjob, qjob;
   queue_stat_type qstat;

   always_comb begin
      cells_wide_in = cells_wide_ff;
      cells_high_in = cells_high_ff;
      tile_edge_in  = tile_edge_ff;
      radius_in     = radius_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_CELLS_WIDE: cells_wide_in = csr_wdata[5:0];
            CSR_CELLS_HIGH: cells_high_in = csr_wdata[5:0];
            CSR_TILE_EDGE:  tile_edge_in  = csr_wdata;
            CSR_RADIUS:     radius_in     = csr_wdata;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cells_wide_ff <= 6'd32;
         cells_high_ff <= 6'd32;
         tile_edge_ff  <= 16'd256;
         radius_ff     <= 16'd64;
      end else begin
         cells_wide_ff <= cells_wide_in;
         cells_high_ff <= cells_high_in;
         tile_edge_ff  <= tile_edge_in;
         radius_ff     <= radius_in;
      end
   end

   // zero counts as one, oversize clamps to the map
   always_comb begin
      if (cells_wide_ff == '0) begin
         eff_w = 6'd1;
      end else if (32'(cells_wide_ff) > MAX_CELLS_WIDE) begin
         eff_w = 6'(MAX_CELLS_WIDE);
      end else begin
         eff_w = cells_wide_ff;
      end
      if (cells_high_ff == '0) begin
         eff_h = 6'd1;
      end else if (32'(cells_high_ff) > MAX_CELLS_HIGH) begin
         eff_h = 6'(MAX_CELLS_HIGH);
      end else begin
         eff_h = cells_high_ff;
      end
   end

   assign tile_edge_eff = (tile_edge_ff == '0) ? 16'd1 : tile_edge_ff;

   tmsc_front u_front (
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tuser   (req_tuser),
      .req_tdata   (req_tdata),
      .body_radius (radius_ff),
      .eff_w       (eff_w),
      .eff_h       (eff_h),
      .clearing    (clearing),
      .qstat       (qstat),
      .push        (push),
      .job         (fjob)
   );

   tmsc_fifo u_fifo (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .din   (fjob),
      .pop   (pop),
      .dout  (qjob),
      .stat  (qstat)
   );

   tmsc_back #(
      .MAX_CELLS_WIDE (MAX_CELLS_WIDE),
      .MAX_CELLS_HIGH (MAX_CELLS_HIGH)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .job           (qjob),
      .qstat         (qstat),
      .job_pop       (pop),
      .eff_w         (eff_w),
      .eff_h         (eff_h),
      .tile_edge_eff (tile_edge_eff),
      .clearing      (clearing),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata)
   );

   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !req_tready)
      else $error("item accepted during tile clear");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      qstat.full |-> !push)
      else $error("queue push while full");

   a_clear_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> clearing)
      else $error("tile clear not running after reset");

endmodule

>>> tb/tb_tile_map_slide_collision.sv
// Testbench for tile_map_slide_collision: maze loads and move resolution checked
// against an in-bench tile map predictor. Depends on tmsc_pkg and the block's RTL.
module tb_tile_map_slide_collision;
   timeunit 1ns;
   timeprecision 1ps;
   import tmsc_pkg::*;

   localparam int TW = 2 * DEF_MAX_CELLS_WIDE + 1;
   localparam int TH = 2 * DEF_MAX_CELLS_HIGH + 1;
   localparam int WATCHDOG_LIMIT = 20000;

   typedef struct packed {
      logic [23:0] x;
      logic [23:0] y;
      logic [23:0] z;
      logic        xt;
      logic        zt;
   } pos_result_type;

   // expected positions of pending moves, plus own copy of the tile map
   class slide_scoreboard;
      bit             solid [TW*TH];
      int unsigned    cells_wide, cells_high, edge_len, radius;
      pos_result_type pending_moves [$];
      int             errors;

      function new();
         foreach (solid[i]) solid[i] = 1'b1;
         cells_wide = 32; cells_high = 32; edge_len = 256; radius = 64;
         errors = 0;
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [15:0] v);
         case (idx)
            CSR_CELLS_WIDE: cells_wide = 32'(v[5:0]);
            CSR_CELLS_HIGH: cells_high = 32'(v[5:0]);
            CSR_TILE_EDGE:  edge_len = 32'(v);
            default:        radius = 32'(v);
         endcase
      endfunction

      function int unsigned eff(int unsigned n);
         return (n == 0) ? 1 : (n > 32 ? 32 : n);
      endfunction

      function void open_tile(int tx, int tz);
         if (tx < TW && tz < TH) solid[tx*TH + tz] = 1'b0;
      endfunction

      function longint fdiv(longint p, longint d);
         if (p >= 0) return p / d;
         return -((-p + d - 1) / d);
      endfunction

      function bit solid_at(longint px, longint pz);
         longint d, tx, tz;
         d = (edge_len == 0) ? 1 : edge_len;
         tx = fdiv(px, d);
         tz = fdiv(pz, d);
         if (tx < 0 || tx >= 2*eff(cells_wide)+1 || tz < 0 || tz >= 2*eff(cells_high)+1)
            return 1'b1;
         return solid[tx*TH + tz];
      endfunction

      function bit blocked(longint x, longint z);
         longint r;
         r = radius;
         return solid_at(x-r, z-r) || solid_at(x-r, z+r) ||
                solid_at(x+r, z-r) || solid_at(x+r, z+r);
      endfunction

      function void note_request(logic cmd, logic [135:0] d);
         int c, r, w, h;
         longint nx, nz, gx, gz, rx, rz;
         pos_result_type res;
         if (cmd == CMD_LOAD) begin
            c = 32'(d[4:0]); r = 32'(d[9:5]);
            w = eff(cells_wide); h = eff(cells_high);
            if (c >= w || r >= h) return;
            open_tile(2*c+1, 2*r+1);
            if (!d[10]) open_tile(2*c+1, 2*r);
            if (!d[13]) open_tile(2*c, 2*r+1);
            if (r == h-1 && !d[11]) open_tile(2*c+1, 2*r+2);
            if (c == w-1 && !d[12]) open_tile(2*c+2, 2*r+1);
            return;
         end
         nx = $signed(d[37:14]); nz = $signed(d[85:62]);
         gx = $signed(d[109:86]); gz = $signed(d[133:110]);
         rx = nx; rz = nz; res = '0;
         if (!blocked(gx, nz)) begin rx = gx; res.xt = 1'b1; end
         if (!blocked(rx, gz)) begin rz = gz; res.zt = 1'b1; end
         res.x = rx[23:0]; res.y = d[61:38]; res.z = rz[23:0];
         pending_moves.push_back(res);
      endfunction

      function void check_result(logic [79:0] d);
         pos_result_type e, a;
         a.x = d[23:0]; a.y = d[47:24]; a.z = d[71:48]; a.xt = d[72]; a.zt = d[73];
         if (pending_moves.size() == 0) begin
            $display("%0t: unexpected result %h", $time, d);
            errors++;
            return;
         end
         e = pending_moves.pop_front();
         if (a !== e || d[79:74] !== 6'd0) begin
            $display("%0t: mismatch expected x=%h y=%h z=%h xt=%b zt=%b", $time,
                     e.x, e.y, e.z, e.xt, e.zt);
            $display("%0t:          actual   x=%h y=%h z=%h xt=%b zt=%b pad=%h", $time,
                     a.x, a.y, a.z, a.xt, a.zt, d[79:74]);
            errors++;
         end
      endfunction
   endclass

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0]   csr_wdata = '0;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic                    req_tuser = 1'b0;
   logic [REQ_TDATA_W-1:0]  req_tdata = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0]  rsp_tdata;

   slide_scoreboard sb = new();
   int  send_idle_pct = 0, recv_idle_pct = 0;
   bit  hold_off = 1'b0;
   int  quiet_cycles = 0;

   always #4 clock = ~clock;

   tile_map_slide_collision dut (.*);

   // response side: random stall, long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
         rsp_tready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > WATCHDOG_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // valid stays high between back-to-back items; drain() drops it
   task automatic send_item(logic cmd, logic [135:0] d);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {2'b00, d[133:0]};
      do @(posedge clock); while (!req_tready);
      sb.note_request(cmd, d);
   endtask

   function automatic logic [135:0] pack_load(int c, int r, logic [3:0] nsew);
      logic [135:0] d;
      d = '0;
      d[4:0] = 5'(c); d[9:5] = 5'(r);
      d[10] = nsew[3]; d[11] = nsew[2]; d[12] = nsew[1]; d[13] = nsew[0];
      d[133:14] = 120'({$urandom, $urandom, $urandom, $urandom});
      return d;
   endfunction

   function automatic logic [135:0] pack_move(logic [23:0] nx, logic [23:0] ny,
                                              logic [23:0] nz, logic [23:0] gx,
                                              logic [23:0] gz);
      logic [135:0] d;
      d = 136'({$urandom, $urandom, $urandom, $urandom, $urandom});
      d[37:14] = nx; d[61:38] = ny; d[85:62] = nz; d[109:86] = gx; d[133:110] = gz;
      return d;
   endfunction

   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.pending_moves.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_INDEX_W-1:0] idx, logic [15:0] v);
      csr_we <= 1'b1; csr_index <= idx; csr_wdata <= v;
      @(posedge clock);
      sb.write_reg(idx, v);
      csr_we <= 1'b0;
   endtask

   // mostly in-map moves of about one tile; some anywhere
   task automatic random_move();
      int span;
      logic [23:0] nx, nz, gx, gz;
      span = (2 * sb.eff(sb.cells_wide) + 1) * ((sb.edge_len == 0) ? 1 : sb.edge_len);
      if ($urandom_range(9) < 8) begin
         nx = 24'($urandom_range(span)); nz = 24'($urandom_range(span));
         gx = 24'(32'(nx) + $urandom_range(2*sb.edge_len) - sb.edge_len);
         gz = 24'(32'(nz) + $urandom_range(2*sb.edge_len) - sb.edge_len);
      end else begin
         nx = 24'($urandom); nz = 24'($urandom); gx = 24'($urandom); gz = 24'($urandom);
      end
      send_item(CMD_MOVE, pack_move(nx, 24'($urandom), nz, gx, gz));
   endtask

   task automatic random_phase(int n);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(2) == 0)
            send_item(CMD_LOAD, pack_load($urandom_range(sb.eff(sb.cells_wide)) % 32,
                      $urandom_range(sb.eff(sb.cells_high)) % 32, 4'($urandom)));
         else if ($urandom_range(19) == 0)
            send_item(CMD_LOAD, pack_load(int'($urandom), int'($urandom), 4'($urandom)));
         else
            random_move();
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: blocked everywhere, then a carved corridor and field extremes
      send_item(CMD_MOVE, pack_move(24'h000180, 24'h7fffff, 24'h000180,
                                    24'h000280, 24'h000280));
      send_item(CMD_MOVE, pack_move(24'h800000, 24'h800000, 24'h7fffff,
                                    24'h7fffff, 24'h800000));
      for (int c = 0; c < 4; c++) send_item(CMD_LOAD, pack_load(c, 0, 4'b1010));
      send_item(CMD_LOAD, pack_load(31, 31, 4'b0000));
      send_item(CMD_LOAD, pack_load(31, 30, 4'b1111));
      send_item(CMD_MOVE, pack_move(24'h000180, 24'h0, 24'h000180,
                                    24'h000480, 24'h000080));
      send_item(CMD_MOVE, pack_move(24'h003f00, 24'h1, 24'h003f00,
                                    24'h004080, 24'h004080));
      send_item(CMD_MOVE, pack_move(24'h000180, 24'h2, 24'h000180,
                                    24'hffff80, 24'h000180));
      drain();
      // zero width, oversize height, zero edge, zero radius, then an out-of-maze and an in-maze load
      write_csr(CSR_CELLS_WIDE, 16'd0);
      write_csr(CSR_CELLS_HIGH, 16'h003f);
      write_csr(CSR_TILE_EDGE, 16'd0);
      write_csr(CSR_RADIUS, 16'd0);
      send_item(CMD_LOAD, pack_load(1, 0, 4'b0000));
      send_item(CMD_LOAD, pack_load(0, 5, 4'b0000));
      send_item(CMD_MOVE, pack_move(24'd1, 24'd0, 24'd1, 24'd2, 24'd2));
      send_item(CMD_MOVE, pack_move(24'd1, 24'd0, 24'd1, 24'd0, 24'd64));
      drain();

      send_idle_pct = 11; recv_idle_pct = 58;
      write_csr(CSR_CELLS_WIDE, 16'd8); write_csr(CSR_CELLS_HIGH, 16'd8);
      write_csr(CSR_TILE_EDGE, 16'd256); write_csr(CSR_RADIUS, 16'd64);
      random_phase(500);
      drain();

      // receiver held off while items keep arriving
      fork
         begin hold_off = 1'b1; repeat (400) @(posedge clock); hold_off = 1'b0; end
         random_phase(40);
      join
      drain();

      send_idle_pct = 58; recv_idle_pct = 11;
      write_csr(CSR_CELLS_WIDE, 16'd32); write_csr(CSR_CELLS_HIGH, 16'd1);
      write_csr(CSR_TILE_EDGE, 16'hffff); write_csr(CSR_RADIUS, 16'hffff);
      random_phase(300);
      drain();
      write_csr(CSR_CELLS_WIDE, 16'd5); write_csr(CSR_CELLS_HIGH, 16'd32);
      write_csr(CSR_TILE_EDGE, 16'd1); write_csr(CSR_RADIUS, 16'd1);
      random_phase(200);
      drain();

      send_idle_pct = 0; recv_idle_pct = 0;
      write_csr(CSR_CELLS_WIDE, 16'd32); write_csr(CSR_CELLS_HIGH, 16'd32);
      write_csr(CSR_TILE_EDGE, 16'd200); write_csr(CSR_RADIUS, 16'd90);
      random_phase(680);
      drain();

      if (sb.errors == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end
endmodule
